### rtl/core/rgb_led_fade_sequencer_macros.svh
// assertion macros for the rgb led fade sequencer
`ifndef RGB_LED_FADE_SEQUENCER_MACROS_SVH
`define RGB_LED_FADE_SEQUENCER_MACROS_SVH

`ifndef SYNTH
`define RLFS_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("rlfs assertion failed");
`define RLFS_ASSERT_NXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("rlfs assertion failed");
`else
`define RLFS_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define RLFS_ASSERT_NXT(label, clk, rst_n, ante, cons)
`endif

`endif

### rtl/core/rlfs_pkg.sv
// shared types and constants of the rgb led fade sequencer
package rlfs_pkg;

  localparam logic [1:0] OP_START  = 2'd0;
  localparam logic [1:0] OP_TICK   = 2'd1;
  localparam logic [1:0] OP_CHANGE = 2'd2;

  localparam logic [1:0] EFF_RISE  = 2'd0;
  localparam logic [1:0] EFF_CROSS = 2'd1;
  localparam logic [1:0] EFF_PAIR  = 2'd2;
  localparam logic [1:0] EFF_WIPE  = 2'd3;

  localparam logic [1:0] CFG_PWM_STEP    = 2'd0;
  localparam logic [1:0] CFG_PHASE_STEPS = 2'd1;
  localparam logic [1:0] CFG_STEP_MS     = 2'd2;
  localparam logic [1:0] CFG_FULL_LEVEL  = 2'd3;

  localparam logic [15:0] PWM_STEP_RST    = 16'd40;
  localparam logic [9:0]  PHASE_STEPS_RST = 10'd50;
  localparam logic [15:0] STEP_MS_RST     = 16'd20;
  localparam logic [15:0] FULL_LEVEL_RST  = 16'd2000;

  typedef struct packed {
    logic [15:0] pwm_step;
    logic [9:0]  phase_steps;
    logic [15:0] step_ms;
    logic [15:0] full_level;
  } cfg_t;

endpackage

### rtl/core/rgb_led_fade_sequencer.sv
// rgb led fade sequencer top level
// a request goes through the request register, a single-pass effect update and
// the result register
// throughput: one request per cycle; the input stalls only while a request waits
// behind a stalled result
// reset: asynchronous active-low; engine duties zero and idle, config at defaults
module rgb_led_fade_sequencer #(
  parameter int DutyBits = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [1:0]  operation_i,
  input  logic [1:0]  effect_select_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [15:0] red_duty_o,
  output logic [15:0] green_duty_o,
  output logic [15:0] blue_duty_o,
  output logic        busy_res_o,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [15:0] cfg_wdata_i
);
  import rlfs_pkg::*;
  `include "rgb_led_fade_sequencer_macros.svh"

  cfg_t                cfg;
  logic                req_valid_q, req_valid_d;
  logic [1:0]          req_op_q, req_sel_q;
  logic                out_valid_q, out_valid_d;
  logic [DutyBits-1:0] red_q, green_q, blue_q;
  logic                busy_q;
  logic [DutyBits-1:0] eng_red, eng_green, eng_blue;
  logic                eng_run, eng_run_cur;
  logic                advance, in_take;

  rlfs_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg)
  );

  rlfs_engine #(
    .DutyBits (DutyBits)
  ) u_engine (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .fire_i          (advance),
    .operation_i     (req_op_q),
    .effect_select_i (req_sel_q),
    .cfg_i           (cfg),
    .red_o           (eng_red),
    .green_o         (eng_green),
    .blue_o          (eng_blue),
    .running_o       (eng_run),
    .running_cur_o   (eng_run_cur)
  );

  assign advance     = req_valid_q && (!out_valid_q || !out_stall_i);
  assign in_stall_o  = req_valid_q && out_valid_q && out_stall_i;
  assign in_take     = in_valid_i && !in_stall_o;
  assign req_valid_d = in_take || (req_valid_q && !advance);
  assign out_valid_d = advance || (out_valid_q && out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      req_valid_q <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      req_valid_q <= req_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      req_op_q  <= operation_i;
      req_sel_q <= effect_select_i;
    end
    if (advance) begin
      red_q   <= eng_red;
      green_q <= eng_green;
      blue_q  <= eng_blue;
      busy_q  <= eng_run;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign red_duty_o   = 16'(red_q);
  assign green_duty_o = 16'(green_q);
  assign blue_duty_o  = 16'(blue_q);
  assign busy_res_o   = busy_q;

  `RLFS_ASSERT_NXT(a_advance_gives_result, clk_i, rst_ni, advance, out_valid_o)
  `RLFS_ASSERT_IMP(a_stall_only_when_blocked, clk_i, rst_ni, in_stall_o,
                   out_valid_q && out_stall_i && req_valid_q)
  `RLFS_ASSERT_IMP(a_only_start_raises_busy, clk_i, rst_ni,
                   advance && (req_op_q != OP_START), !eng_run || eng_run_cur)

endmodule

### rtl/core/rlfs_cfg_regs.sv
// configuration register file of the fade sequencer
module rlfs_cfg_regs (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          cfg_we_i,
  input  logic [1:0]    cfg_idx_i,
  input  logic [15:0]   cfg_wdata_i,
  output rlfs_pkg::cfg_t cfg_o
);
  import rlfs_pkg::*;

  cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_PWM_STEP:    cfg_d.pwm_step    = cfg_wdata_i;
        CFG_PHASE_STEPS: cfg_d.phase_steps = cfg_wdata_i[9:0];
        CFG_STEP_MS:     cfg_d.step_ms     = cfg_wdata_i;
        CFG_FULL_LEVEL:  cfg_d.full_level  = cfg_wdata_i;
        default:         cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.pwm_step    <= PWM_STEP_RST;
      cfg_q.phase_steps <= PHASE_STEPS_RST;
      cfg_q.step_ms     <= STEP_MS_RST;
      cfg_q.full_level  <= FULL_LEVEL_RST;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

### rtl/core/rlfs_engine.sv
// effect sequencing state and per-request duty update
module rlfs_engine #(
  parameter int DutyBits = 16
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                fire_i,
  input  logic [1:0]          operation_i,
  input  logic [1:0]          effect_select_i,
  input  rlfs_pkg::cfg_t      cfg_i,
  output logic [DutyBits-1:0] red_o,
  output logic [DutyBits-1:0] green_o,
  output logic [DutyBits-1:0] blue_o,
  output logic                running_o,
  output logic                running_cur_o
);
  import rlfs_pkg::*;

  logic [DutyBits-1:0] red_q, red_d, green_q, green_d, blue_q, blue_d;
  logic [1:0]          effect_q, effect_d;
  logic [1:0]          phase_q, phase_d;
  logic [9:0]          iter_q, iter_d;
  logic [16:0]         delay_q, delay_d;
  logic                abort_q, abort_d;
  logic                running_q, running_d;

  logic [DutyBits-1:0] step, full;
  logic [16:0]         ms, total_ms, delay_inc;
  logic [9:0]          iter_inc;
  logic                steps_zero;
  logic                ent_go;
  logic [2:0]          ent_p;
  logic [2:0]          ph_total;
  logic                upd_en;
  logic [1:0]          upd_p;

  assign step       = cfg_i.pwm_step[DutyBits-1:0];
  assign full       = cfg_i.full_level[DutyBits-1:0];
  assign steps_zero = (cfg_i.phase_steps == 10'd0);
  assign ms         = (cfg_i.step_ms == 16'd0) ? 17'd1 : {1'b0, cfg_i.step_ms};
  assign total_ms   = (effect_q == EFF_WIPE) ? {ms[15:0], 1'b0} : ms;
  assign delay_inc  = delay_q + 17'd1;
  assign iter_inc   = iter_q + 10'd1;

  always_comb begin
    logic [2:0] kk;
    logic       hit;
    red_d     = red_q;
    green_d   = green_q;
    blue_d    = blue_q;
    effect_d  = effect_q;
    phase_d   = phase_q;
    iter_d    = iter_q;
    delay_d   = delay_q;
    abort_d   = abort_q;
    running_d = running_q;
    ent_go    = 1'b0;
    ent_p     = 3'd0;
    upd_en    = 1'b0;
    upd_p     = phase_q;
    kk        = 3'd0;
    hit       = 1'b0;

    if (fire_i) begin
      case (operation_i)
        OP_START: begin
          effect_d  = effect_select_i;
          running_d = 1'b1;
          ent_go    = 1'b1;
          ent_p     = 3'd0;
        end
        OP_TICK: begin
          if (running_q) begin
            delay_d = delay_inc;
            if ((effect_q == EFF_WIPE) && (delay_inc == ms) && abort_q) begin
              abort_d   = 1'b0;
              running_d = 1'b0;
            end else if (delay_inc >= total_ms) begin
              iter_d = iter_inc;
              if (iter_inc >= cfg_i.phase_steps) begin
                ent_go = 1'b1;
                ent_p  = {1'b0, phase_q} + 3'd1;
              end else begin
                upd_en = 1'b1;
                upd_p  = phase_q;
              end
            end
          end
        end
        OP_CHANGE: abort_d = 1'b1;
        default: ;
      endcase
    end

    ph_total = (effect_d == EFF_WIPE) ? 3'd4 : 3'd3;

    // phase entry loads, chained through skipped phases
    if (ent_go) begin
      for (int k = 0; k < 5; k++) begin
        kk  = 3'(k);
        hit = (kk >= ent_p) && ((kk == ent_p) || (steps_zero && (kk <= ph_total)));
        if (hit) begin
          case (effect_d)
            EFF_CROSS: begin
              if (kk == 3'd0) blue_d = full;
            end
            EFF_PAIR: begin
              if (kk == 3'd1) begin
                green_d = '0;
                red_d   = '0;
              end else if (kk == 3'd2) begin
                green_d = '0;
                blue_d  = '0;
              end
            end
            EFF_WIPE: begin
              case (kk)
                3'd0: begin
                  blue_d = '0;
                  red_d  = full;
                end
                3'd1: begin
                  blue_d = full;
                  red_d  = '0;
                end
                3'd2: begin
                  red_d   = '0;
                  blue_d  = '0;
                  green_d = full;
                end
                3'd3: begin
                  blue_d  = full;
                  green_d = '0;
                end
                default: green_d = '0;
              endcase
            end
            default: ;
          endcase
        end
      end
      if (!steps_zero && (ent_p < ph_total)) begin
        phase_d = ent_p[1:0];
        iter_d  = 10'd0;
        upd_en  = 1'b1;
        upd_p   = ent_p[1:0];
      end else begin
        running_d = 1'b0;
      end
    end

    // one iteration of the ramp
    if (upd_en) begin
      delay_d = 17'd0;
      case ({effect_d, upd_p})
        {EFF_RISE, 2'd0}:  red_d   = red_d + step;
        {EFF_RISE, 2'd1}:  green_d = green_d + step;
        {EFF_RISE, 2'd2}:  blue_d  = blue_d + step;
        {EFF_CROSS, 2'd0}: begin
          blue_d = blue_d - step;
          red_d  = red_d + step;
        end
        {EFF_CROSS, 2'd1}: begin
          red_d   = red_d - step;
          green_d = green_d + step;
        end
        {EFF_CROSS, 2'd2}: begin
          green_d = green_d - step;
          blue_d  = blue_d + step;
        end
        {EFF_PAIR, 2'd0}: begin
          green_d = green_d + step;
          red_d   = red_d + step;
        end
        {EFF_PAIR, 2'd1}: begin
          green_d = green_d + step;
          blue_d  = blue_d + step;
        end
        {EFF_PAIR, 2'd2}: begin
          blue_d = blue_d + step;
          red_d  = red_d + step;
        end
        {EFF_WIPE, 2'd0}:  blue_d  = blue_d + step;
        {EFF_WIPE, 2'd1}:  red_d   = red_d + step;
        {EFF_WIPE, 2'd2}:  blue_d  = blue_d + step;
        {EFF_WIPE, 2'd3}:  green_d = green_d + step;
        default: ;
      endcase
      if ((effect_d != EFF_WIPE) && abort_d) begin
        abort_d   = 1'b0;
        running_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      red_q     <= '0;
      green_q   <= '0;
      blue_q    <= '0;
      effect_q  <= 2'd0;
      phase_q   <= 2'd0;
      iter_q    <= 10'd0;
      delay_q   <= 17'd0;
      abort_q   <= 1'b0;
      running_q <= 1'b0;
    end else begin
      red_q     <= red_d;
      green_q   <= green_d;
      blue_q    <= blue_d;
      effect_q  <= effect_d;
      phase_q   <= phase_d;
      iter_q    <= iter_d;
      delay_q   <= delay_d;
      abort_q   <= abort_d;
      running_q <= running_d;
    end
  end

  assign red_o         = red_d;
  assign green_o       = green_d;
  assign blue_o        = blue_d;
  assign running_o     = running_d;
  assign running_cur_o = running_q;

endmodule
